FILE: rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared constants and types of the frame deframer
// Holds sizes, parse phases and the parser state record.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int MaxPayload  = 64;
  localparam int HeaderBytes = 8;
  localparam int RetainDepth = HeaderBytes + MaxPayload + 2;
  localparam int PayAw       = $clog2(MaxPayload);
  localparam int RetAw       = $clog2(RetainDepth);
  localparam int CntW        = $clog2(RetainDepth + 1);
  localparam int LenW        = $clog2(MaxPayload + 1);

  typedef enum logic [3:0] {
    PhHunt1, PhHunt2, PhLen, PhSeq1, PhSeq2, PhId,
    PhHsumLo, PhHsumHi, PhPayload, PhFsumLo, PhFsumHi
  } phase_e;

  typedef enum logic [1:0] {StMore, StBad, StDone} status_e;

  typedef struct packed {
    phase_e          phase;
    logic [15:0]     hsum;
    logic [15:0]     fsum;
    logic [LenW-1:0] len;
    logic [7:0]      id;
    logic [LenW-1:0] cnt;
  } pstate_t;

endpackage

FILE: rtl/cfd_parser.sv
// ----------------------------------------------------------------------------
// cfd_parser: one parse step of the frame state machine
// Combinational next state, status and payload store write for one byte.
// ----------------------------------------------------------------------------
module cfd_parser (
  input  cfd_pkg::pstate_t             st_i,
  input  logic [7:0]                   b_i,
  input  logic [7:0]                   start1_i,
  input  logic [7:0]                   start2_i,
  output cfd_pkg::pstate_t             st_o,
  output cfd_pkg::status_e             status_o,
  output logic                         pwe_o,
  output logic [cfd_pkg::PayAw-1:0]    pwa_o
);

  logic [15:0] b16;
  assign b16 = {8'd0, b_i};

  // step the parse phase for one byte
  always_comb begin
    st_o     = st_i;
    status_o = cfd_pkg::StMore;
    pwe_o    = 1'b0;
    pwa_o    = st_i.cnt[cfd_pkg::PayAw-1:0];
    unique case (st_i.phase)
      cfd_pkg::PhHunt1: begin
        if (b_i == start1_i) begin
          st_o.hsum  = b16;
          st_o.fsum  = b16;
          st_o.cnt   = '0;
          st_o.phase = cfd_pkg::PhHunt2;
        end
      end
      cfd_pkg::PhHunt2: begin
        if (b_i == start2_i) begin
          st_o.hsum  = st_i.hsum + b16;
          st_o.fsum  = st_i.fsum + b16;
          st_o.phase = cfd_pkg::PhLen;
        end else begin
          st_o.phase = cfd_pkg::PhHunt1;
        end
      end
      cfd_pkg::PhLen: begin
        if (b_i == 8'd0 || b_i > 8'(cfd_pkg::MaxPayload)) begin
          st_o.phase = cfd_pkg::PhHunt1;
          status_o   = cfd_pkg::StBad;
        end else begin
          st_o.len   = b_i[cfd_pkg::LenW-1:0];
          st_o.hsum  = st_i.hsum + b16;
          st_o.fsum  = st_i.fsum + b16;
          st_o.phase = cfd_pkg::PhSeq1;
        end
      end
      cfd_pkg::PhSeq1, cfd_pkg::PhSeq2, cfd_pkg::PhId: begin
        st_o.hsum = st_i.hsum + b16;
        st_o.fsum = st_i.fsum + b16;
        if (st_i.phase == cfd_pkg::PhId) st_o.id = b_i;
        st_o.phase = (st_i.phase == cfd_pkg::PhSeq1) ? cfd_pkg::PhSeq2 :
                     (st_i.phase == cfd_pkg::PhSeq2) ? cfd_pkg::PhId :
                                                       cfd_pkg::PhHsumLo;
      end
      cfd_pkg::PhHsumLo: begin
        if (b_i != st_i.hsum[7:0]) begin
          st_o.phase = cfd_pkg::PhHunt1;
          status_o   = cfd_pkg::StBad;
        end else begin
          st_o.fsum  = st_i.fsum + b16;
          st_o.phase = cfd_pkg::PhHsumHi;
        end
      end
      cfd_pkg::PhHsumHi: begin
        if (b_i != st_i.hsum[15:8]) begin
          st_o.phase = cfd_pkg::PhHunt1;
          status_o   = cfd_pkg::StBad;
        end else begin
          st_o.fsum  = st_i.fsum + b16;
          st_o.cnt   = '0;
          st_o.phase = cfd_pkg::PhPayload;
        end
      end
      cfd_pkg::PhPayload: begin
        st_o.fsum = st_i.fsum + b16;
        pwe_o     = (st_i.cnt < cfd_pkg::LenW'(cfd_pkg::MaxPayload));
        st_o.cnt  = st_i.cnt + 1'b1;
        if (st_i.cnt + 1'b1 >= st_i.len) st_o.phase = cfd_pkg::PhFsumLo;
      end
      cfd_pkg::PhFsumLo: begin
        st_o.phase = cfd_pkg::PhHunt1;
        if (b_i != st_i.fsum[7:0]) status_o = cfd_pkg::StBad;
        else st_o.phase = cfd_pkg::PhFsumHi;
      end
      cfd_pkg::PhFsumHi: begin
        st_o.phase = cfd_pkg::PhHunt1;
        status_o   = (b_i != st_i.fsum[15:8]) ? cfd_pkg::StBad : cfd_pkg::StDone;
      end
      default: st_o.phase = cfd_pkg::PhHunt1;
    endcase
  end

endmodule

FILE: rtl/checksummed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_core: start-byte, length and sum frame parser
// Hunts frames, checks header and frame sums, emits payload bytes.
// ----------------------------------------------------------------------------
// Bytes are taken only while the core is idle. A frame that passes its sums
// is sent out as length payload bytes read from the payload memory, each by
// a memory read, an output load and a hand-over that waits while the output
// stalls; no byte is taken until the last one is handed over. A failed sum
// or bad length starts a rescan that reads the retained-byte memory one entry
// at a time, a read and then a parse for each, and no byte is taken until it
// ends and any frame found in it is sent out. Payload and retained bytes
// live in two one-port-read synchronous memories; no clearing pass is needed
// after reset.
module checksummed_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_position_o,
  output logic [6:0] payload_length_o,
  output logic [7:0] message_id_o,
  output logic       last_byte_o
);

  localparam logic [2:0] AddrStart1 = 3'd0;
  localparam logic [2:0] AddrStart2 = 3'd4;

  typedef enum logic [2:0] {SIdle, SScanRd, SScanPar, SEmitRd, SEmitOut} mode_e;

  logic [7:0] start1_q, start2_q;
  mode_e mode_q;
  cfd_pkg::pstate_t ps_q, ps_d, par_in;
  cfd_pkg::status_e status;
  logic [7:0] par_b;
  logic pwe;
  logic [cfd_pkg::PayAw-1:0] pwa;
  logic [cfd_pkg::CntW-1:0] rcnt_q, scan_q, ecnt_q;
  logic [7:0] pay_mem [cfd_pkg::MaxPayload];
  logic [7:0] ret_mem [cfd_pkg::RetainDepth];
  logic [7:0] pay_rd_q, ret_rd_q;
  logic [cfd_pkg::LenW-1:0] elen;
  logic accept, outacc;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr == AddrStart1) prdata = {24'd0, start1_q};
    else if (paddr == AddrStart2) prdata = {24'd0, start2_q};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start1_q <= 8'hAA;
      start2_q <= 8'h55;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrStart1) start1_q <= pwdata[7:0];
      if (paddr == AddrStart2) start2_q <= pwdata[7:0];
    end
  end

  assign rx_stall_o = (mode_q != SIdle);
  assign accept     = rx_valid_i && !rx_stall_o;
  assign outacc     = out_valid_o && !out_stall_i;
  assign par_b  = (mode_q == SScanPar) ? ret_rd_q : rx_byte_i;
  assign par_in = ps_q;

  cfd_parser u_parser (
    .st_i(par_in), .b_i(par_b), .start1_i(start1_q), .start2_i(start2_q),
    .st_o(ps_d), .status_o(status), .pwe_o(pwe), .pwa_o(pwa)
  );

  assign elen = (ps_q.len > cfd_pkg::LenW'(cfd_pkg::MaxPayload)) ?
                cfd_pkg::LenW'(cfd_pkg::MaxPayload) : ps_q.len;

  // memories
  always_ff @(posedge clk_i) begin
    if (pwe && (accept || mode_q == SScanPar)) pay_mem[pwa] <= par_b;
    if (accept && rcnt_q < cfd_pkg::CntW'(cfd_pkg::RetainDepth) &&
        (ps_q.phase != cfd_pkg::PhHunt1 || ps_d.phase == cfd_pkg::PhHunt2))
      ret_mem[(ps_q.phase == cfd_pkg::PhHunt1) ? '0 : rcnt_q[cfd_pkg::RetAw-1:0]]
        <= rx_byte_i;
    ret_rd_q <= ret_mem[scan_q[cfd_pkg::RetAw-1:0]];
    pay_rd_q <= pay_mem[ecnt_q[cfd_pkg::PayAw-1:0]];
  end

  // sequencer: accept, rescan, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= SIdle;
      ps_q             <= '0;
      rcnt_q           <= '0;
      scan_q           <= '0;
      ecnt_q           <= '0;
      out_valid_o      <= 1'b0;
      payload_byte_o   <= '0;
      byte_position_o  <= '0;
      payload_length_o <= '0;
      message_id_o     <= '0;
      last_byte_o      <= 1'b0;
    end else begin
      unique case (mode_q)
        SIdle: begin
          if (accept) begin
            ps_q <= ps_d;
            if (ps_q.phase == cfd_pkg::PhHunt1) begin
              rcnt_q <= (ps_d.phase == cfd_pkg::PhHunt2) ? cfd_pkg::CntW'(1) : '0;
            end else if (rcnt_q < cfd_pkg::CntW'(cfd_pkg::RetainDepth)) begin
              rcnt_q <= rcnt_q + 1'b1;
            end
            if (status == cfd_pkg::StDone) begin
              ecnt_q <= '0;
              mode_q <= SEmitRd;
            end else if (status == cfd_pkg::StBad) begin
              scan_q <= cfd_pkg::CntW'(1);
              mode_q <= SScanRd;
            end
          end
        end
        SScanRd: begin
          // end of retained bytes: hunt again
          if (scan_q >= rcnt_q) begin
            ps_q.phase <= cfd_pkg::PhHunt1;
            rcnt_q     <= '0;
            mode_q     <= SIdle;
          end else begin
            mode_q <= SScanPar;
          end
        end
        SScanPar: begin
          ps_q   <= ps_d;
          scan_q <= scan_q + 1'b1;
          if (status == cfd_pkg::StDone) begin
            ecnt_q <= '0;
            mode_q <= SEmitRd;
          end else begin
            mode_q <= SScanRd;
          end
        end
        SEmitRd: begin
          mode_q <= SEmitOut;
        end
        SEmitOut: begin
          if (!out_valid_o) begin
            out_valid_o      <= 1'b1;
            payload_byte_o   <= pay_rd_q;
            byte_position_o  <= ecnt_q[5:0];
            payload_length_o <= ps_q.len;
            message_id_o     <= ps_q.id;
            last_byte_o      <= (ecnt_q + 1'b1 == cfd_pkg::CntW'(elen));
          end else if (outacc) begin
            out_valid_o <= 1'b0;
            if (last_byte_o) begin
              ps_q.phase <= cfd_pkg::PhHunt1;
              rcnt_q     <= '0;
              mode_q     <= SIdle;
            end else begin
              ecnt_q <= ecnt_q + 1'b1;
              mode_q <= SEmitRd;
            end
          end
        end
        default: mode_q <= SIdle;
      endcase
    end
  end

endmodule
